// ===== rtl/point_in_polygon_crossing_test_core_macros.svh =====
// Assertion helpers for the top-level RTL file, which checks itself.
`ifndef POINT_IN_POLYGON_CROSSING_TEST_CORE_MACROS_SVH
`define POINT_IN_POLYGON_CROSSING_TEST_CORE_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define PIPCT_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("pipct assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PIPCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pipct assertion failed");

`endif

// ===== rtl/pipct_pkg.sv =====
package pipct_pkg;

    localparam int LAT_W      = 24;
    localparam int LON_W      = 25;
    localparam int ID_W       = 16;
    localparam int DLAT_W     = LAT_W + 1;
    localparam int DLON_W     = LON_W + 1;
    localparam int PROD_W     = DLAT_W + DLON_W;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;
    localparam int CFG_DATA_W = 25;

    typedef enum logic [0:0] {
        CFG_POINT_LAT = 1'b0,
        CFG_POINT_LON = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
    } t_vertex;

    // One accepted vertex: edge prev->cur, and on the last vertex cur->first
    typedef struct packed {
        logic            start;
        logic            last;
        logic [ID_W-1:0] id;
        t_vertex         prev;
        t_vertex         cur;
        t_vertex         first;
    } t_job;

    typedef struct packed {
        logic               have_prev;
        logic [Q_CNT_W-1:0] job_cnt;
    } t_front_stat;

    typedef struct packed {
        logic               stall;
        logic [Q_CNT_W-1:0] res_cnt;
    } t_back_stat;

endpackage

// ===== rtl/pipct_front.sv =====
module pipct_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  pipct_pkg::t_vertex             i_vtx,
    input  logic [pipct_pkg::ID_W-1:0]     i_id,
    input  logic                           i_last,
    output logic                           o_full,
    input  logic                           i_job_pop,
    output logic                           o_job_valid,
    output pipct_pkg::t_job                o_job,
    output pipct_pkg::t_front_stat         o_stat
);

    pipct_pkg::t_vertex r_first;
    pipct_pkg::t_vertex r_prev;
    logic               r_have_prev;

    pipct_pkg::t_job                    r_q [pipct_pkg::Q_DEPTH];
    logic [pipct_pkg::Q_PTR_W-1:0]      r_wr_ptr;
    logic [pipct_pkg::Q_PTR_W-1:0]      r_rd_ptr;
    logic [pipct_pkg::Q_CNT_W-1:0]      r_cnt;

    pipct_pkg::t_job n_job;
    logic            accept;
    logic            take;

    assign o_full      = (r_cnt == pipct_pkg::Q_CNT_W'(pipct_pkg::Q_DEPTH));
    assign accept      = i_push && !o_full;
    assign o_job_valid = (r_cnt != '0);
    assign take        = i_job_pop && o_job_valid;
    assign o_job       = r_q[r_rd_ptr];

    assign o_stat.have_prev = r_have_prev;
    assign o_stat.job_cnt   = r_cnt;

    always_comb begin
        n_job.start = !r_have_prev;
        n_job.last  = i_last;
        n_job.id    = i_id;
        n_job.prev  = r_prev;
        n_job.cur   = i_vtx;
        // a vertex that opens a polygon is its own first vertex
        n_job.first = r_have_prev ? r_first : i_vtx;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= n_job;
            r_prev        <= i_vtx;
            if (!r_have_prev) begin
                r_first <= i_vtx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_cnt       <= '0;
        end else begin
            if (accept) begin
                r_have_prev <= !i_last;
                r_wr_ptr    <= r_wr_ptr + 1'b1;
            end
            if (take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({accept, take})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/pipct_back.sv =====
module pipct_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [pipct_pkg::LAT_W-1:0]  i_point_lat,
    input  logic signed [pipct_pkg::LON_W-1:0]  i_point_lon,
    input  logic                                i_job_valid,
    input  pipct_pkg::t_job                     i_job,
    output logic                                o_job_pop,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic [pipct_pkg::ID_W-1:0]          o_result_id,
    output logic                                o_inside_res,
    output pipct_pkg::t_back_stat               o_stat
);

    typedef struct packed {
        logic                               ok;
        logic                               dxpos;
        logic signed [pipct_pkg::DLAT_W-1:0] dx;
        logic signed [pipct_pkg::DLON_W-1:0] dy;
        logic signed [pipct_pkg::DLON_W-1:0] ex;
        logic signed [pipct_pkg::DLAT_W-1:0] ey;
    } t_pre;

    typedef struct packed {
        logic                                ok;
        logic                                dxpos;
        logic signed [pipct_pkg::PROD_W-1:0] lhs;
        logic signed [pipct_pkg::PROD_W-1:0] rhs;
    } t_prod;

    function automatic t_pre edge_pre(
        input logic signed [pipct_pkg::LAT_W-1:0] plat,
        input logic signed [pipct_pkg::LON_W-1:0] plon,
        input logic signed [pipct_pkg::LAT_W-1:0] alat,
        input logic signed [pipct_pkg::LON_W-1:0] alon,
        input logic signed [pipct_pkg::LAT_W-1:0] blat,
        input logic signed [pipct_pkg::LON_W-1:0] blon
    );
        logic signed [pipct_pkg::LAT_W-1:0] lo;
        logic signed [pipct_pkg::LAT_W-1:0] hi;
        t_pre                               p;
        lo      = (alat < blat) ? alat : blat;
        hi      = (alat < blat) ? blat : alat;
        // a flat edge has lo == hi, so the span test drops it
        p.ok    = (plat > lo) && (plat <= hi) && ((plon < alon) || (plon <= blon));
        p.dx    = {blat[pipct_pkg::LAT_W-1], blat} - {alat[pipct_pkg::LAT_W-1], alat};
        p.dy    = {blon[pipct_pkg::LON_W-1], blon} - {alon[pipct_pkg::LON_W-1], alon};
        p.ex    = {plon[pipct_pkg::LON_W-1], plon} - {alon[pipct_pkg::LON_W-1], alon};
        p.ey    = {plat[pipct_pkg::LAT_W-1], plat} - {alat[pipct_pkg::LAT_W-1], alat};
        p.dxpos = !p.dx[pipct_pkg::DLAT_W-1] && (p.dx != '0);
        return p;
    endfunction

    function automatic t_prod edge_mul(input t_pre p);
        t_prod q;
        q.ok    = p.ok;
        q.dxpos = p.dxpos;
        q.lhs   = $signed(p.ex) * $signed(p.dx);
        q.rhs   = $signed(p.dy) * $signed(p.ey);
        return q;
    endfunction

    function automatic logic edge_hit(input t_prod q);
        logic le;
        logic ge;
        le = ($signed(q.lhs) <= $signed(q.rhs));
        ge = ($signed(q.lhs) >= $signed(q.rhs));
        return q.ok && (q.dxpos ? le : ge);
    endfunction

    // stage 1: differences and span tests
    logic                          r_s1_valid;
    logic                          r_s1_start;
    logic                          r_s1_last;
    logic [pipct_pkg::ID_W-1:0]    r_s1_id;
    t_pre                          r_s1_e1;
    t_pre                          r_s1_e2;

    // stage 2: cross products
    logic                          r_s2_valid;
    logic                          r_s2_start;
    logic                          r_s2_last;
    logic [pipct_pkg::ID_W-1:0]    r_s2_id;
    t_prod                         r_s2_e1;
    t_prod                         r_s2_e2;

    logic                          r_parity;

    logic [pipct_pkg::ID_W-1:0]    r_rq_id [pipct_pkg::Q_DEPTH];
    logic                          r_rq_in [pipct_pkg::Q_DEPTH];
    logic [pipct_pkg::Q_PTR_W-1:0] r_rq_wr;
    logic [pipct_pkg::Q_PTR_W-1:0] r_rq_rd;
    logic [pipct_pkg::Q_CNT_W-1:0] r_rq_cnt;

    t_pre  e1_pre;
    t_pre  e2_pre;
    logic  res_full;
    logic  stall;
    logic  en;
    logic  n_parity;
    logic  res_push;
    logic  res_take;

    assign res_full  = (r_rq_cnt == pipct_pkg::Q_CNT_W'(pipct_pkg::Q_DEPTH));
    assign stall     = r_s2_valid && r_s2_last && res_full;
    assign en        = !stall;
    assign o_job_pop = en && i_job_valid;

    always_comb begin
        e1_pre = edge_pre(i_point_lat, i_point_lon,
                          i_job.prev.lat, i_job.prev.lon, i_job.cur.lat, i_job.cur.lon);
        // no edge into the opening vertex
        if (i_job.start) begin
            e1_pre.ok = 1'b0;
        end
        e2_pre = edge_pre(i_point_lat, i_point_lon,
                          i_job.cur.lat, i_job.cur.lon, i_job.first.lat, i_job.first.lon);
        if (!i_job.last) begin
            e2_pre.ok = 1'b0;
        end
    end

    assign n_parity = (r_s2_start ? 1'b0 : r_parity)
                      ^ edge_hit(r_s2_e1) ^ edge_hit(r_s2_e2);
    assign res_push = en && r_s2_valid && r_s2_last;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_start <= i_job.start;
            r_s1_last  <= i_job.last;
            r_s1_id    <= i_job.id;
            r_s1_e1    <= e1_pre;
            r_s1_e2    <= e2_pre;
            r_s2_start <= r_s1_start;
            r_s2_last  <= r_s1_last;
            r_s2_id    <= r_s1_id;
            r_s2_e1    <= edge_mul(r_s1_e1);
            r_s2_e2    <= edge_mul(r_s1_e2);
        end
        if (res_push) begin
            r_rq_id[r_rq_wr] <= r_s2_id;
            r_rq_in[r_rq_wr] <= n_parity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_parity   <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_job_valid;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid) begin
                r_parity <= r_s2_last ? 1'b0 : n_parity;
            end
        end
    end

    assign o_empty      = (r_rq_cnt == '0);
    assign res_take     = i_pop && !o_empty;
    assign o_result_id  = r_rq_id[r_rq_rd];
    assign o_inside_res = r_rq_in[r_rq_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wr  <= '0;
            r_rq_rd  <= '0;
            r_rq_cnt <= '0;
        end else begin
            if (res_push) begin
                r_rq_wr <= r_rq_wr + 1'b1;
            end
            if (res_take) begin
                r_rq_rd <= r_rq_rd + 1'b1;
            end
            case ({res_push, res_take})
                2'b10:   r_rq_cnt <= r_rq_cnt + 1'b1;
                2'b01:   r_rq_cnt <= r_rq_cnt - 1'b1;
                default: r_rq_cnt <= r_rq_cnt;
            endcase
        end
    end

    assign o_stat.stall   = stall;
    assign o_stat.res_cnt = r_rq_cnt;

endmodule

// ===== rtl/point_in_polygon_crossing_test_core.sv =====
// Ray-casting point-in-polygon test. Load the query point (latitude, then
// longitude, signed Q8.16 and Q9.16) through the configuration port while the
// block is idle, then push polygon vertices one per clock, marking the final
// vertex of each polygon. One vertex is accepted every clock cycle while the
// vertex queue is not full; a result (polygon id and inside flag) reaches the
// result queue once its final vertex has passed the vertex queue, the difference
// stage and the cross-product stage, where both edges of a final vertex are
// tested side by side on four 26x25 multipliers. Both queues hold four entries.
`include "point_in_polygon_crossing_test_core_macros.svh"

module point_in_polygon_crossing_test_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [pipct_pkg::LAT_W-1:0]    i_vertex_lat,
    input  logic signed [pipct_pkg::LON_W-1:0]    i_vertex_lon,
    input  logic [pipct_pkg::ID_W-1:0]            i_polygon_id,
    input  logic                                  i_last_vertex,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [pipct_pkg::ID_W-1:0]            o_result_id,
    output logic                                  o_inside_res,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic                                  i_cfg_index,
    input  logic [pipct_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic signed [pipct_pkg::LAT_W-1:0] r_point_lat;
    logic signed [pipct_pkg::LON_W-1:0] r_point_lon;

    pipct_pkg::t_vertex     vtx;
    pipct_pkg::t_job        job;
    logic                   job_valid;
    logic                   job_pop;
    pipct_pkg::t_front_stat front_stat;
    pipct_pkg::t_back_stat  back_stat;

    assign o_cfg_ready = 1'b1;
    assign vtx.lat     = i_vertex_lat;
    assign vtx.lon     = i_vertex_lon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_lat <= '0;
            r_point_lon <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (pipct_pkg::t_cfg_idx'(i_cfg_index))
                pipct_pkg::CFG_POINT_LAT: r_point_lat <= i_cfg_data[pipct_pkg::LAT_W-1:0];
                pipct_pkg::CFG_POINT_LON: r_point_lon <= i_cfg_data[pipct_pkg::LON_W-1:0];
                default: ;
            endcase
        end
    end

    pipct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_vtx       (vtx),
        .i_id        (i_polygon_id),
        .i_last      (i_last_vertex),
        .o_full      (full),
        .i_job_pop   (job_pop),
        .o_job_valid (job_valid),
        .o_job       (job),
        .o_stat      (front_stat)
    );

    pipct_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_point_lat  (r_point_lat),
        .i_point_lon  (r_point_lon),
        .i_job_valid  (job_valid),
        .i_job        (job),
        .o_job_pop    (job_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result_id  (o_result_id),
        .o_inside_res (o_inside_res),
        .o_stat       (back_stat)
    );

    `PIPCT_ASSERT_NEXT(a_last_closes, push && !full && i_last_vertex, !front_stat.have_prev)
    `PIPCT_ASSERT_NEXT(a_vertex_opens, push && !full && !i_last_vertex, front_stat.have_prev)
    `PIPCT_ASSERT_ALWAYS(a_stall_only_full, !back_stat.stall || (back_stat.res_cnt == pipct_pkg::Q_CNT_W'(pipct_pkg::Q_DEPTH)))
    `PIPCT_ASSERT_ALWAYS(a_job_cnt_bound, front_stat.job_cnt <= pipct_pkg::Q_CNT_W'(pipct_pkg::Q_DEPTH))

endmodule

// ===== bench/point_in_polygon_crossing_test_core_test.sv =====
`timescale 1ns / 100ps

module point_in_polygon_crossing_test_core_test;
    import pipct_pkg::*;

    localparam longint LAT_MAX = 5898240;
    localparam longint LON_MAX = 11796480;
    localparam longint DEG     = 65536;
    localparam int     SETTLE  = 8;

    typedef struct {
        logic [ID_W-1:0] id;
        logic            in_flag;
    } t_verdict;

    // Ray-casting predictor with the queue of verdicts still owed by the block
    class crossing_scoreboard;
        longint   pt_lat, pt_lon;
        longint   first_lat, first_lon, prev_lat, prev_lon;
        bit       have_prev, parity;
        int       mismatches;
        t_verdict verdicts_due[$];

        function new();
            pt_lat = 0;
            pt_lon = 0;
            first_lat = 0;
            first_lon = 0;
            prev_lat = 0;
            prev_lon = 0;
            have_prev = 0;
            parity = 0;
            mismatches = 0;
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns: %s", $time, msg);
            mismatches++;
        endtask

        function int pending();
            return verdicts_due.size();
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            logic signed [LAT_W-1:0] s_lat;
            logic signed [LON_W-1:0] s_lon;
            s_lat = value[LAT_W-1:0];
            s_lon = value[LON_W-1:0];
            if (idx == CFG_POINT_LAT) begin
                pt_lat = s_lat;
            end else begin
                pt_lon = s_lon;
            end
        endfunction

        // Edge a->b flips parity when the ray from the point crosses it
        function bit crosses(longint alat, longint alon, longint blat, longint blon);
            longint lo, hi, dlat, dlon, lhs, rhs;
            lo = (alat < blat) ? alat : blat;
            hi = (alat < blat) ? blat : alat;
            if (!(pt_lat > lo && pt_lat <= hi)) return 1'b0;
            if (!(pt_lon < alon || pt_lon <= blon)) return 1'b0;
            dlat = blat - alat;
            dlon = blon - alon;
            lhs = (pt_lon - alon) * dlat;
            rhs = dlon * (pt_lat - alat);
            if (dlat > 0) return lhs <= rhs;
            return lhs >= rhs;
        endfunction

        function void note_vertex(logic signed [LAT_W-1:0] lat,
                                  logic signed [LON_W-1:0] lon,
                                  logic [ID_W-1:0] id, logic last);
            longint   vlat, vlon;
            t_verdict v;
            vlat = lat;
            vlon = lon;
            if (!have_prev) begin
                first_lat = vlat;
                first_lon = vlon;
                parity = 1'b0;
                have_prev = 1'b1;
            end else begin
                parity ^= crosses(prev_lat, prev_lon, vlat, vlon);
            end
            prev_lat = vlat;
            prev_lon = vlon;
            if (last) begin
                parity ^= crosses(vlat, vlon, first_lat, first_lon);
                v.id = id;
                v.in_flag = parity;
                verdicts_due.push_back(v);
                have_prev = 1'b0;
                parity = 1'b0;
            end
        endfunction

        task check_verdict(logic [ID_W-1:0] id, logic in_flag);
            t_verdict v;
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result id=%h inside=%b", id, in_flag));
            end else begin
                v = verdicts_due.pop_front();
                if (id !== v.id)
                    report_mismatch($sformatf("result_id %h, want %h", id, v.id));
                if (in_flag !== v.in_flag)
                    report_mismatch($sformatf("inside_res %b, want %b (id %h)",
                                              in_flag, v.in_flag, v.id));
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic signed [LAT_W-1:0] i_vertex_lat;
    logic signed [LON_W-1:0] i_vertex_lon;
    logic [ID_W-1:0]       i_polygon_id;
    logic                  i_last_vertex;
    logic                  empty;
    logic                  pop;
    logic [ID_W-1:0]       o_result_id;
    logic                  o_inside_res;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic                  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    crossing_scoreboard sb;
    bit     calm;
    int     vertices_sent;
    longint center_lat, center_lon;

    point_in_polygon_crossing_test_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_vertex_lat  (i_vertex_lat),
        .i_vertex_lon  (i_vertex_lon),
        .i_polygon_id  (i_polygon_id),
        .i_last_vertex (i_last_vertex),
        .empty         (empty),
        .pop           (pop),
        .o_result_id   (o_result_id),
        .o_inside_res  (o_inside_res),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                sb.note_vertex(i_vertex_lat, i_vertex_lon, i_polygon_id, i_last_vertex);
            if (pop && !empty)
                sb.check_verdict(o_result_id, o_inside_res);
        end
    end

    // Hold a write request until taken; the caller drops valid after its last write
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, value);
    endtask

    task automatic set_point(logic [CFG_DATA_W-1:0] lat_raw, logic [CFG_DATA_W-1:0] lon_raw);
        logic signed [LAT_W-1:0] s_lat;
        logic signed [LON_W-1:0] s_lon;
        s_lat = lat_raw[LAT_W-1:0];
        s_lon = lon_raw[LON_W-1:0];
        write_reg(CFG_POINT_LAT, lat_raw);
        write_reg(CFG_POINT_LON, lon_raw);
        i_cfg_valid <= 1'b0;
        center_lat = s_lat;
        center_lon = s_lon;
    endtask

    task automatic send_vertex(longint lat, longint lon, logic [ID_W-1:0] id, bit last,
                               int odds);
        if (!calm && odds != 0 && $urandom_range(0, odds - 1) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_vertex_lat  <= lat[LAT_W-1:0];
        i_vertex_lon  <= lon[LON_W-1:0];
        i_polygon_id  <= id;
        i_last_vertex <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        vertices_sent++;
    endtask

    // Stop pushing, wait for every owed verdict, then let the pipeline empty
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Polygon scattered around the query point, with ties and wild values mixed in
    task automatic send_polygon();
        int              nv, spread, odds, k;
        logic [ID_W-1:0] base_id, id;
        longint          lat, lon, prev_lat;
        case ($urandom_range(0, 11))
            0: nv = 1;
            1: nv = 2;
            default: nv = $urandom_range(3, 9);
        endcase
        case ($urandom_range(0, 4))
            0: spread = 3;
            1: spread = 400;
            2: spread = 65536;
            3: spread = 1500000;
            default: spread = 6000000;
        endcase
        case ($urandom_range(0, 2))
            0: odds = 0;
            1: odds = 3;
            default: odds = 10;
        endcase
        base_id = ID_W'($urandom);
        prev_lat = center_lat;
        for (k = 0; k < nv; k++) begin
            lat = center_lat + longint'($urandom_range(0, 2 * spread)) - spread;
            lon = center_lon + longint'($urandom_range(0, 2 * spread)) - spread;
            case ($urandom_range(0, 15))
                0, 1: lat = center_lat;
                2: lat = prev_lat;
                3: lon = center_lon;
                4: begin
                    lat = longint'($urandom);
                    lon = longint'($urandom);
                end
                default: ;
            endcase
            id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : base_id;
            send_vertex(lat, lon, id, k == nv - 1, odds);
            prev_lat = lat;
        end
    endtask

    initial begin
        int                    ph, target;
        bit                    paused;
        logic [CFG_DATA_W-1:0] lat_raw, lon_raw;
        sb = new();
        calm = 1'b0;
        vertices_sent = 0;
        paused = 1'b0;
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_vertex_lat  <= '0;
        i_vertex_lon  <= '0;
        i_polygon_id  <= '0;
        i_last_vertex <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_POINT_LAT;
        i_cfg_data    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_point('0, '0);
        // square around the point: inside
        send_vertex(-DEG, -DEG, 16'h0001, 1'b0, 4);
        send_vertex(DEG, -DEG, 16'h0001, 1'b0, 4);
        send_vertex(DEG, DEG, 16'h0001, 1'b0, 4);
        send_vertex(-DEG, DEG, 16'h0001, 1'b1, 4);
        // single-vertex polygons
        send_vertex(0, 0, 16'hFFFF, 1'b1, 4);
        send_vertex(LAT_MAX, LON_MAX, 16'h0000, 1'b1, 4);
        // flat edge only
        send_vertex(0, -DEG, 16'h0007, 1'b0, 4);
        send_vertex(0, DEG, 16'h0007, 1'b1, 4);
        // whole globe box, mixed ids
        send_vertex(-LAT_MAX, -LON_MAX, 16'h0000, 1'b0, 4);
        send_vertex(LAT_MAX, -LON_MAX, 16'h1234, 1'b0, 4);
        send_vertex(LAT_MAX, LON_MAX, 16'h8000, 1'b0, 4);
        send_vertex(-LAT_MAX, LON_MAX, 16'hFFFF, 1'b1, 4);
        // raw extremes of the field widths
        send_vertex(-8388608, -16777216, 16'h5555, 1'b0, 4);
        send_vertex(8388607, -16777216, 16'h5555, 1'b0, 4);
        send_vertex(8388607, 16777215, 16'hAAAA, 1'b1, 4);
        // point latitude on a vertex, polygon off to the east
        send_vertex(0, DEG, 16'h0010, 1'b0, 4);
        send_vertex(DEG, 2 * DEG, 16'h0010, 1'b0, 4);
        send_vertex(-DEG, 2 * DEG, 16'h0010, 1'b1, 4);
        // point sitting on a vertex
        send_vertex(0, 0, 16'h0020, 1'b0, 4);
        send_vertex(DEG, DEG, 16'h0020, 1'b0, 4);
        send_vertex(DEG, -DEG, 16'h0020, 1'b1, 4);

        for (ph = 1; ph <= 5; ph++) begin
            drain();
            case (ph)
                1: begin
                    lat_raw = CFG_DATA_W'(LAT_MAX);
                    lon_raw = CFG_DATA_W'(LON_MAX);
                end
                2: begin
                    lat_raw = CFG_DATA_W'(-LAT_MAX);
                    lon_raw = CFG_DATA_W'(-LON_MAX);
                end
                4: begin
                    lat_raw = CFG_DATA_W'($urandom);
                    lon_raw = CFG_DATA_W'($urandom);
                end
                default: begin
                    lat_raw = CFG_DATA_W'(longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
                    lon_raw = CFG_DATA_W'(longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
                end
            endcase
            set_point(lat_raw, lon_raw);
            if (ph == 5) calm = 1'b1;
            target = vertices_sent + 165;
            while (vertices_sent < target) begin
                send_polygon();
                if (ph == 3 && !paused && vertices_sent > target - 80) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side: stall in random bursts, never once the run turns calm
    initial begin
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
